>>> hw/rtl/scb_pkg.sv
package scb_pkg;

    // Field and register widths fixed by the item format
    localparam int REQ_BYTES_W  = 16;
    localparam int HANDLE_W     = 8;
    localparam int CLASS_W      = 4;
    localparam int STATUS_W     = 3;
    localparam int HEAP_BYTES_W = 17;
    localparam int COUNT_W      = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;

    localparam logic [HEAP_BYTES_W-1:0] HEAP_BYTES_MAX = '1;
    localparam logic [COUNT_W-1:0]      COUNT_MAX      = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CACHE_BLOCK_LIMIT = 1'b0,
        REG_HEAP_EXTRA_BYTES  = 1'b1
    } t_cfg_reg;

    // Request opcodes
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_CACHED    = 3'd3,
        ST_RELEASE   = 3'd4
    } t_status;

    typedef struct packed {
        logic                   op;
        logic [REQ_BYTES_W-1:0] req_bytes;
        logic [HANDLE_W-1:0]    buf_handle;
        logic [CLASS_W-1:0]     buf_class;
    } t_req_item;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [HANDLE_W-1:0]     out_handle;
        logic [CLASS_W-1:0]      out_class;
        logic [HEAP_BYTES_W-1:0] heap_bytes;
    } t_rsp_item;

endpackage

>>> hw/rtl/scb_stream_if.sv
interface scb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/size_class_buffer_cache_core.sv
// Size-class buffer cache: one LIFO free list of buffer handles per size class.
// Channels: i_req (sink) takes allocate/free requests, o_rsp (source) gives one
// result per request. Both transfer on a clock edge with valid and ready high.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write cache_block_limit (0) and
// heap_extra_bytes (1); write only while no request is in flight.
// A request is held in the input register; its result is loaded into the
// output register when the output slot is free and transfers out from there.
// Throughput: one request per cycle while o_rsp is not held off. A pop reads
// the link memory (registered read) and writes the new list head in the cycle
// after; the following request sees that head through a bypass, so
// back-to-back pops on the same class do not wait.
// Reset (synchronous, active low): all lists empty, cached block count zero,
// limit 32, extra bytes 96, both channels empty. The link memory is not
// cleared; only entries written by a free are ever followed.
// Stall: while o_rsp is held off, the result holds, the input register holds
// its request and i_req.ready drops once that register is full.
module size_class_buffer_cache_core #(
    parameter int NUM_CLASSES = 16,
    parameter int BLOCK_SHIFT = 7,
    parameter int HANDLE_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [scb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [scb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    scb_stream_if.sink                    i_req,
    scb_stream_if.source                  o_rsp
);
    import scb_pkg::*;

    localparam int CLS_BITS  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int LINK_W    = HANDLE_BITS + 1;
    localparam int DEPTH     = 1 << HANDLE_BITS;
    localparam int CLS_SUM_W = REQ_BYTES_W + 1;
    localparam int HB_SUM_W  = 20;

    // Configuration registers
    logic [COUNT_W-1:0]    r_limit;
    logic [CFG_DATA_W-1:0] r_extra;

    // Input and output registers
    logic      r_in_vld;
    t_req_item r_in;
    logic      r_out_vld;
    t_rsp_item r_out;

    // List state
    logic [NUM_CLASSES-1:0] r_head_vld;
    logic [NUM_CLASSES-1:0] n_head_vld;
    logic [NUM_CLASSES-1:0][HANDLE_BITS-1:0] r_head_hdl;
    logic [NUM_CLASSES-1:0][HANDLE_BITS-1:0] n_head_hdl;
    logic [LINK_W-1:0]      r_links [DEPTH];
    logic [LINK_W-1:0]      r_link_rd;
    logic                   r_pop_pend;
    logic [CLS_BITS-1:0]    r_pop_cls;
    logic [COUNT_W-1:0]     r_count;
    logic [COUNT_W-1:0]     n_count;

    logic                   fire;
    logic [CLS_SUM_W-1:0]   cls_sum;
    logic [CLS_SUM_W-1:0]   cls_full;
    logic [CLS_SUM_W-1:0]   bcls_ext;
    logic                   in_range;
    logic [CLS_BITS-1:0]    c_idx;
    logic [COUNT_W-1:0]     c_val;
    logic                   fwd;
    logic                   head_vld;
    logic [HANDLE_BITS-1:0] head_hdl;
    logic [HANDLE_BITS-1:0] hdl;
    logic                   do_pop;
    logic                   do_push;
    logic [COUNT_W:0]       push_sum;
    logic [HB_SUM_W-1:0]    hb_sum;
    logic [15:0]            hdl_ext;
    t_rsp_item              n_out;

    // Handshake: the input register advances when the output slot frees up
    assign fire        = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || fire;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    // Round the byte size up to a class and pick the list index
    assign cls_sum  = {1'b0, r_in.req_bytes} + CLS_SUM_W'((1 << BLOCK_SHIFT) - 1);
    assign cls_full = cls_sum >> BLOCK_SHIFT;
    assign bcls_ext = CLS_SUM_W'(r_in.buf_class);
    assign in_range = (r_in.op == OP_FREE) ? (bcls_ext < CLS_SUM_W'(NUM_CLASSES))
                                           : (cls_full < CLS_SUM_W'(NUM_CLASSES));
    assign c_idx    = (r_in.op == OP_FREE) ? bcls_ext[CLS_BITS-1:0]
                                           : cls_full[CLS_BITS-1:0];
    assign c_val    = COUNT_W'(c_idx);
    assign hdl_ext  = 16'(r_in.buf_handle);
    assign hdl      = hdl_ext[HANDLE_BITS-1:0];

    // Bypass the head that a pending pop is about to write
    assign fwd      = r_pop_pend && (r_pop_cls == c_idx);
    assign head_vld = fwd ? r_link_rd[HANDLE_BITS] : r_head_vld[c_idx];
    assign head_hdl = fwd ? r_link_rd[HANDLE_BITS-1:0] : r_head_hdl[c_idx];

    assign do_pop   = (r_in.op == OP_ALLOC) && in_range && head_vld;
    assign do_push  = (r_in.op == OP_FREE) && in_range && (r_count <= r_limit);
    assign push_sum = {1'b0, r_count} + {1'b0, c_val};
    assign hb_sum   = (HB_SUM_W'(c_idx) << BLOCK_SHIFT) + HB_SUM_W'(r_extra);

    // Next cached block count, saturating both ways
    always_comb begin
        n_count = r_count;
        if (do_pop) begin
            n_count = (r_count >= c_val) ? (r_count - c_val) : '0;
        end else if (do_push) begin
            n_count = push_sum[COUNT_W] ? COUNT_MAX : push_sum[COUNT_W-1:0];
        end
    end

    // Next list heads: the later push wins over an older pop on the same class
    always_comb begin
        n_head_vld = r_head_vld;
        n_head_hdl = r_head_hdl;
        if (r_pop_pend) begin
            n_head_vld[r_pop_cls] = r_link_rd[HANDLE_BITS];
            n_head_hdl[r_pop_cls] = r_link_rd[HANDLE_BITS-1:0];
        end
        if (fire && do_push) begin
            n_head_vld[c_idx] = 1'b1;
            n_head_hdl[c_idx] = hdl;
        end
    end

    // Build the result item
    always_comb begin
        n_out = '0;
        if (r_in.op == OP_ALLOC) begin
            n_out.out_class = cls_full[CLASS_W-1:0];
            if (!in_range) begin
                n_out.status = ST_TOO_LARGE;
            end else if (head_vld) begin
                n_out.status     = ST_HIT;
                n_out.out_handle = HANDLE_W'(16'(head_hdl));
            end else begin
                n_out.status     = ST_MISS;
                n_out.heap_bytes = (hb_sum > HB_SUM_W'(HEAP_BYTES_MAX)) ?
                                   HEAP_BYTES_MAX : hb_sum[HEAP_BYTES_W-1:0];
            end
        end else begin
            n_out.out_class  = r_in.buf_class;
            n_out.out_handle = HANDLE_W'(hdl);
            n_out.status     = do_push ? ST_CACHED : ST_RELEASE;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 16'd32;
            r_extra <= 16'd96;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CACHE_BLOCK_LIMIT: r_limit <= i_cfg_data;
                REG_HEAP_EXTRA_BYTES:  r_extra <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control: channel valids, pending pop, count, head valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pop_pend <= 1'b0;
            r_count    <= '0;
            r_head_vld <= '0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            r_pop_pend <= fire && do_pop;
            if (fire) begin
                r_count <= n_count;
            end
            r_head_vld <= n_head_vld;
        end
    end

    // Payload: request, result, head handles, pending pop class
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
        if (fire) begin
            r_out     <= n_out;
            r_pop_cls <= c_idx;
        end
        r_head_hdl <= n_head_hdl;
    end

    // Link memory: push writes the old head, pop reads the next link
    always_ff @(posedge i_clk) begin
        if (fire && do_push) begin
            r_links[hdl] <= {head_vld, head_hdl};
        end
        if (fire && do_pop) begin
            r_link_rd <= r_links[head_hdl];
        end
    end

    // A pending pop always comes from a transfer in the cycle before
    a_pop_from_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pop_pend |-> $past(fire))
        else $error("pending pop without a preceding hit");

    // A cached free leaves its list non-empty
    a_push_sets_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && do_push) |=> r_head_vld[r_pop_cls])
        else $error("list head not valid after a cached free");

    // Only a miss asks the heap for bytes
    a_heap_only_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.status != ST_MISS)) |-> (r_out.heap_bytes == '0))
        else $error("heap bytes given on a result that is not a miss");

endmodule

>>> bench/size_class_buffer_cache_core_tb.sv
module size_class_buffer_cache_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scb_pkg::*;

    localparam int NUM_CLASSES = 16;
    localparam int BLOCK_SHIFT = 7;
    localparam int HANDLE_BITS = 8;
    localparam int HANDLE_COUNT = 1 << HANDLE_BITS;
    localparam int LINK_VALID = HANDLE_BITS;
    localparam int RSP_LATENCY = 8;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_SPARSE
    } t_stall_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    scb_stream_if #(.T(t_req_item)) req_if ();
    scb_stream_if #(.T(t_rsp_item)) rsp_if ();

    size_class_buffer_cache_core #(
        .NUM_CLASSES(NUM_CLASSES),
        .BLOCK_SHIFT(BLOCK_SHIFT),
        .HANDLE_BITS(HANDLE_BITS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_req     (req_if),
        .o_rsp     (rsp_if)
    );

    // Shadow copy of the cache state and its registers
    logic [HANDLE_BITS:0] head_table [NUM_CLASSES];
    logic [HANDLE_BITS:0] link_table [HANDLE_COUNT];
    logic [COUNT_W-1:0]   cached_blocks;
    logic [15:0]          block_limit;
    logic [15:0]          heap_extra;

    t_rsp_item   pending_results [$];
    int unsigned error_count;
    int unsigned burst_left;
    bit          gaps_on;

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Work out the result of one request and advance the shadow state
    function automatic t_rsp_item predict_cache_result(input t_req_item req);
        t_rsp_item            rsp;
        int unsigned          cls;
        int unsigned          sum;
        logic [HANDLE_BITS-1:0] hnd;
        rsp = '0;
        if (req.op == OP_ALLOC) begin
            cls = (32'(req.req_bytes) + (32'd1 << BLOCK_SHIFT) - 32'd1) >> BLOCK_SHIFT;
            rsp.out_class = cls[CLASS_W-1:0];
            if (cls >= NUM_CLASSES) begin
                rsp.status = ST_TOO_LARGE;
            end else if (head_table[cls][LINK_VALID]) begin
                hnd = head_table[cls][HANDLE_BITS-1:0];
                head_table[cls] = link_table[hnd];
                cached_blocks = (cached_blocks >= cls) ? cached_blocks - cls[COUNT_W-1:0] : '0;
                rsp.status = ST_HIT;
                rsp.out_handle = HANDLE_W'(hnd);
            end else begin
                sum = (cls << BLOCK_SHIFT) + 32'(heap_extra);
                rsp.status = ST_MISS;
                rsp.heap_bytes = (sum > 32'(HEAP_BYTES_MAX)) ? HEAP_BYTES_MAX
                                                             : sum[HEAP_BYTES_W-1:0];
            end
        end else begin
            hnd = req.buf_handle[HANDLE_BITS-1:0];
            rsp.out_handle = HANDLE_W'(hnd);
            rsp.out_class = req.buf_class;
            if (32'(req.buf_class) < NUM_CLASSES && cached_blocks <= block_limit) begin
                link_table[hnd] = head_table[req.buf_class];
                head_table[req.buf_class] = {1'b1, hnd};
                sum = 32'(cached_blocks) + 32'(req.buf_class);
                cached_blocks = (sum > 32'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
                rsp.status = ST_CACHED;
            end else begin
                rsp.status = ST_RELEASE;
            end
        end
        return rsp;
    endfunction

    function automatic t_req_item make_alloc(input logic [REQ_BYTES_W-1:0] nbytes);
        t_req_item item;
        item.op = OP_ALLOC;
        item.req_bytes = nbytes;
        item.buf_handle = HANDLE_W'($urandom);
        item.buf_class = CLASS_W'($urandom);
        return item;
    endfunction

    function automatic t_req_item make_free(input logic [HANDLE_W-1:0] hnd,
                                            input logic [CLASS_W-1:0] cls);
        t_req_item item;
        item.op = OP_FREE;
        item.req_bytes = REQ_BYTES_W'($urandom);
        item.buf_handle = hnd;
        item.buf_class = cls;
        return item;
    endfunction

    // Random byte count that rounds up to the given class
    function automatic logic [REQ_BYTES_W-1:0] bytes_in_class(input int unsigned cls);
        if (cls == 0) return '0;
        return REQ_BYTES_W'((cls << BLOCK_SHIFT) - $urandom_range(0, (1 << BLOCK_SHIFT) - 1));
    endfunction

    // Transfer one request, idling between bursts, and queue its expected result
    task automatic send_req(input t_req_item item);
        int unsigned gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.data <= item;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(predict_cache_result(item));
    endtask

    // Hold off the sender until every result is back
    task automatic wait_results_done();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CACHE_BLOCK_LIMIT: block_limit = value;
            REG_HEAP_EXTRA_BYTES:  heap_extra = value;
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_rsp_item want;
        t_rsp_item got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("out_handle", 32'(want.out_handle), 32'(got.out_handle));
                check_field("out_class", 32'(want.out_class), 32'(got.out_class));
                check_field("heap_bytes", 32'(want.heap_bytes), 32'(got.heap_bytes));
            end
        end
    end

    // Receiver back-pressure: switch at random among stall patterns
    initial begin : rsp_stall_pattern
        t_stall_mode mode;
        int unsigned mode_left;
        rsp_if.ready = 1'b0;
        mode = STALL_NONE;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode = t_stall_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                STALL_NONE:   rsp_if.ready <= 1'b1;
                STALL_RANDOM: rsp_if.ready <= 1'($urandom_range(0, 1));
                default:      rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Class rounding edges, hits, misses, too-large, double free, limit release
    task automatic test_directed();
        send_req(make_alloc(16'd0));
        send_req(make_alloc(16'd1));
        send_req(make_alloc(16'd128));
        send_req(make_alloc(16'd129));
        send_req(make_alloc(16'd1920));
        send_req(make_alloc(16'd1921));
        send_req(make_alloc(16'hFFFF));
        send_req(make_free(8'h00, 4'd0));
        send_req(make_free(8'hFF, 4'd15));
        send_req(make_alloc(16'd1793));
        send_req(make_alloc(16'd0));
        // double free makes the list loop on itself
        send_req(make_free(8'hA5, 4'd3));
        send_req(make_free(8'hA5, 4'd3));
        send_req(make_alloc(16'd384));
        send_req(make_alloc(16'd384));
        send_req(make_alloc(16'd300));
        // climb past the default limit, then release
        send_req(make_free(8'h5A, 4'd15));
        send_req(make_free(8'h5B, 4'd15));
        send_req(make_free(8'h5C, 4'd15));
        send_req(make_free(8'h3C, 4'd9));
        send_req(make_alloc(16'd1900));
        send_req(make_alloc(16'd1152));
        wait_results_done();
    endtask

    // Register extremes: zero limit with largest headroom, then the reverse
    task automatic test_config_extremes();
        write_reg(REG_CACHE_BLOCK_LIMIT, 16'd0);
        write_reg(REG_HEAP_EXTRA_BYTES, 16'hFFFF);
        send_req(make_alloc(16'd1920));
        send_req(make_alloc(16'd0));
        send_req(make_free(8'h11, 4'd5));
        send_req(make_free(8'h12, 4'd6));
        wait_results_done();
        write_reg(REG_CACHE_BLOCK_LIMIT, 16'hFFFF);
        write_reg(REG_HEAP_EXTRA_BYTES, 16'd0);
        send_req(make_alloc(16'd1));
        send_req(make_free(8'hC8, 4'd15));
        send_req(make_alloc(16'd1900));
        send_req(make_alloc(16'd1900));
        wait_results_done();
    endtask

    // Mostly balanced alloc/free traffic on a few classes, with some noise
    task automatic test_random_traffic();
        int unsigned lo_cls;
        int unsigned cls;
        int unsigned pick;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 3))
                0:       write_reg(REG_CACHE_BLOCK_LIMIT, 16'd0);
                1:       write_reg(REG_CACHE_BLOCK_LIMIT, 16'hFFFF);
                default: write_reg(REG_CACHE_BLOCK_LIMIT, 16'($urandom_range(0, 300)));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(REG_HEAP_EXTRA_BYTES, 16'd0);
                1:       write_reg(REG_HEAP_EXTRA_BYTES, 16'hFFFF);
                default: write_reg(REG_HEAP_EXTRA_BYTES, 16'($urandom));
            endcase
            gaps_on = (phase != 2);
            lo_cls = $urandom_range(0, NUM_CLASSES - 4);
            for (int n = 0; n < 235; n++) begin
                if (phase == 3 && n == 120) wait_results_done();
                cls = lo_cls + $urandom_range(0, 3);
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_req(make_alloc(bytes_in_class(cls)));
                else if (pick < 90)
                    send_req(make_free(8'($urandom), 4'(cls)));
                else if (pick < 95)
                    send_req(make_alloc(16'($urandom)));
                else
                    send_req(make_free(8'($urandom), 4'($urandom)));
            end
            wait_results_done();
        end
        gaps_on = 1'b1;
    endtask

    // Pop a self-looped list back to back until the block count bottoms out at zero
    task automatic test_count_saturation();
        write_reg(REG_CACHE_BLOCK_LIMIT, 16'hFFFF);
        gaps_on = 1'b0;
        repeat (3) send_req(make_free(8'h77, 4'd14));
        for (int k = 0; k < 48; k++) begin
            if (cached_blocks == 0 || !head_table[14][LINK_VALID]) break;
            send_req(make_alloc(16'd1792));
        end
        repeat (2) send_req(make_alloc(16'd1792));
        wait_results_done();
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_CACHE_BLOCK_LIMIT;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        error_count = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        for (int c = 0; c < NUM_CLASSES; c++) head_table[c] = '0;
        for (int h = 0; h < HANDLE_COUNT; h++) link_table[h] = '0;
        cached_blocks = '0;
        block_limit = 16'd32;
        heap_extra = 16'd96;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_config_extremes();
        test_random_traffic();
        test_count_saturation();

        wait_results_done();
        repeat (RSP_LATENCY) @(posedge i_clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run limit
    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
